// ===== design/mrf_pkg.sv =====
// ----------------------------------------------------------------------------
// mrf_pkg: shared types and constants of the Modbus RTU request framer
// Holds the function codes, the CRC-16 constants, the word carried through
// the CRC pipeline and the helpers that pick and fold one frame byte.
// ----------------------------------------------------------------------------
`default_nettype none

package mrf_pkg;

  localparam logic [7:0]  FC_READ_HOLDING = 8'd3;
  localparam logic [7:0]  FC_WRITE_SINGLE = 8'd6;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam int          BODY_LEN        = 6;
  localparam int          FRAME_LEN       = 8;
  localparam int          IDX_W           = 3;
  localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(FRAME_LEN - 1);

  // Byte positions inside the frame.
  localparam logic [IDX_W-1:0] POS_SLAVE    = 3'd0;
  localparam logic [IDX_W-1:0] POS_FUNC     = 3'd1;
  localparam logic [IDX_W-1:0] POS_START_HI = 3'd2;
  localparam logic [IDX_W-1:0] POS_START_LO = 3'd3;
  localparam logic [IDX_W-1:0] POS_VOC_HI   = 3'd4;
  localparam logic [IDX_W-1:0] POS_VOC_LO   = 3'd5;
  localparam logic [IDX_W-1:0] POS_CRC_LO   = 3'd6;
  localparam logic [IDX_W-1:0] POS_CRC_HI   = 3'd7;

  // One request plus its running CRC.
  typedef struct packed {
    logic [7:0]  slave_address;
    logic [7:0]  function_code;
    logic [15:0] start_address;
    logic [15:0] value_or_count;
    logic [15:0] crc;
  } word_t;

  // Frame byte at a given position; the CRC positions read the stored CRC.
  function automatic logic [7:0] frame_byte(input word_t w, input logic [IDX_W-1:0] pos);
    logic [7:0] b;
    unique case (pos)
      POS_SLAVE:    b = w.slave_address;
      POS_FUNC:     b = w.function_code;
      POS_START_HI: b = w.start_address[15:8];
      POS_START_LO: b = w.start_address[7:0];
      POS_VOC_HI:   b = w.value_or_count[15:8];
      POS_VOC_LO:   b = w.value_or_count[7:0];
      POS_CRC_LO:   b = w.crc[7:0];
      POS_CRC_HI:   b = w.crc[15:8];
      default:      b = 8'h00;
    endcase
    return b;
  endfunction

  // Folds one byte into the reflected CRC-16, LSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/mrf_crc_stage.sv =====
// ----------------------------------------------------------------------------
// mrf_crc_stage: one register stage of the CRC pipeline
// Folds one frame byte into the running CRC and holds the word until the
// next stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mrf_crc_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          up_valid,
  output logic               up_ready,
  input  wire mrf_pkg::word_t up_word,
  input  wire logic [7:0]    up_byte,
  output logic               dn_valid,
  input  wire logic          dn_ready,
  output mrf_pkg::word_t     dn_word
);

  logic           valid_r;
  logic           valid_nxt;
  mrf_pkg::word_t word_r;
  mrf_pkg::word_t word_nxt;

  // The stage takes a word when it is empty or its word leaves this cycle.
  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    valid_nxt = up_ready ? up_valid : valid_r;
    word_nxt  = up_word;
    word_nxt.crc = mrf_pkg::crc_byte(up_word.crc, up_byte);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      word_r <= word_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_word  = word_r;

endmodule

`default_nettype wire

// ===== design/mrf_serializer.sv =====
// ----------------------------------------------------------------------------
// mrf_serializer: frame holding register and byte sequencer
// Holds one finished frame and hands out its eight bytes in transmit order.
// ----------------------------------------------------------------------------
`default_nettype none

module mrf_serializer (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire mrf_pkg::word_t in_word,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          out_byte,
  output logic                out_last
);

  logic                        valid_r;
  logic                        valid_nxt;
  logic [mrf_pkg::IDX_W-1:0]   idx_r;
  logic [mrf_pkg::IDX_W-1:0]   idx_nxt;
  mrf_pkg::word_t              frame_r;
  logic                        take;
  logic                        load;

  assign out_last = (idx_r == mrf_pkg::IDX_LAST);
  assign take     = valid_r && out_ready;
  // A new frame may load in the same cycle that the last byte leaves.
  assign in_ready = !valid_r || (out_ready && out_last);
  assign load     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = '0;
    end else if (take) begin
      if (out_last) begin
        valid_nxt = 1'b0;
        idx_nxt   = '0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_r <= in_word;
    end
  end

  assign out_valid = valid_r;
  assign out_byte  = mrf_pkg::frame_byte(frame_r, idx_r);

endmodule

`default_nettype wire

// ===== design/modbus_rtu_request_framer_core.sv =====
// Path: an accepted word passes through the six CRC stages and then the serializer.
// Throughput: one frame byte per cycle while out_ready is high; the byte sequencer at the
// output sets that rate, and the six-stage CRC pipeline takes up to six more requests
// while a frame is being sent.
// Reset: synchronous, active low; it empties every stage and the output holding register.
// ----------------------------------------------------------------------------
// modbus_rtu_request_framer_core: Modbus RTU master request framer
// Turns one request word into the eight-byte RTU frame with its CRC-16.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_request_framer_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_function_code,
  input  wire logic [7:0]  in_slave_address,
  input  wire logic [15:0] in_start_address,
  input  wire logic [15:0] in_value_or_count,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_frame_byte,
  output logic             out_last_byte
);

  // The CRC runs over the six body bytes, one byte per pipeline stage. Each
  // stage carries the whole request along with the running CRC, so the last
  // stage hands a complete frame to the serializer. Words with a function
  // code other than read holding registers or write single register are
  // accepted but never enter the pipeline, so they produce no bytes.

  localparam int NSTG = mrf_pkg::BODY_LEN;

  logic            stg_valid [NSTG+1];
  logic            stg_ready [NSTG+1];
  mrf_pkg::word_t  stg_word  [NSTG+1];
  logic            fc_ok;

  assign fc_ok = (in_function_code == mrf_pkg::FC_READ_HOLDING) ||
                 (in_function_code == mrf_pkg::FC_WRITE_SINGLE);

  // Entry into the pipeline; the CRC starts at its preset value.
  assign stg_valid[0]                = in_valid && fc_ok;
  assign stg_word[0].slave_address   = in_slave_address;
  assign stg_word[0].function_code   = in_function_code;
  assign stg_word[0].start_address   = in_start_address;
  assign stg_word[0].value_or_count  = in_value_or_count;
  assign stg_word[0].crc             = mrf_pkg::CRC_INIT;
  assign in_ready                    = stg_ready[0];

  for (genvar g = 0; g < NSTG; g++) begin : g_stage
    mrf_crc_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stg_valid[g]),
      .up_ready (stg_ready[g]),
      .up_word  (stg_word[g]),
      .up_byte  (mrf_pkg::frame_byte(stg_word[g], mrf_pkg::IDX_W'(g))),
      .dn_valid (stg_valid[g+1]),
      .dn_ready (stg_ready[g+1]),
      .dn_word  (stg_word[g+1])
    );
  end

  // The serializer holds the finished frame and sends it one byte a cycle while out_ready is high.
  mrf_serializer u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (stg_valid[NSTG]),
    .in_ready  (stg_ready[NSTG]),
    .in_word   (stg_word[NSTG]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_frame_byte),
    .out_last  (out_last_byte)
  );

  // Only supported requests may occupy the first stage.
  a_entry_fc: assert property (@(posedge clk) disable iff (!rst_n)
    stg_valid[1] |-> (stg_word[1].function_code == mrf_pkg::FC_READ_HOLDING) ||
                     (stg_word[1].function_code == mrf_pkg::FC_WRITE_SINGLE))
    else $error("unsupported function code entered the CRC pipeline");

  // A frame never breaks off before its last byte.
  a_frame_whole: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_byte) |=> out_valid)
    else $error("frame ended before its last byte");

  // The serializer must accept the next frame when the last byte leaves.
  a_reload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_byte) |-> stg_ready[NSTG])
    else $error("serializer not ready after last byte");

endmodule

`default_nettype wire
